>>> rtl/core/speck96_pkg.sv
// ----------------------------------------------------------------------------
// speck96_pkg
// shared widths, register indexes, stage payload type and rotate helpers
// for the speck 96/96 cipher core
// ----------------------------------------------------------------------------
package speck96_pkg;

  localparam int WORD_W          = 48;
  localparam int ALPHA           = 8;
  localparam int BETA            = 3;
  localparam int ROUND_COUNT_DEF = 28;
  localparam int DATA_W          = 2 * WORD_W;
  localparam int CFG_INDEX_W     = 2;

  typedef logic [WORD_W-1:0] word_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

  // item mode codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // key schedule sequencer
  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_RUN
  } ks_state_t;

  // payload carried from one round stage to the next
  typedef struct packed {
    logic  mode;
    word_t y;
    word_t x;
  } stage_t;

  function automatic word_t rotr(input word_t v, input int n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} >> n;
    return d[WORD_W-1:0];
  endfunction

  function automatic word_t rotl(input word_t v, input int n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

endpackage

>>> rtl/core/speck96_keys.sv
// ----------------------------------------------------------------------------
// speck96_keys
// key registers and key schedule: expands the two key words into the round
// key store, one round key per cycle, after reset and after every key write
// ----------------------------------------------------------------------------
module speck96_keys #(
  parameter int ROUND_COUNT = speck96_pkg::ROUND_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [speck96_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [speck96_pkg::WORD_W-1:0]       cfg_data,
  output logic [speck96_pkg::WORD_W-1:0]       round_keys [ROUND_COUNT],
  output logic                                 keys_ready
);
  import speck96_pkg::*;

  localparam int CNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROUND_COUNT - 2);

  ks_state_t        state, state_next;
  word_t            key_low, key_high;
  word_t            k, l;
  word_t            l_step, k_step;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] wr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_KEY_LOW) begin
        key_low <= cfg_data;
      end else if (cfg_index == REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      KS_IDLE: state_next = KS_IDLE;
      KS_LOAD: state_next = (ROUND_COUNT > 1) ? KS_RUN : KS_IDLE;
      KS_RUN:  state_next = (cnt == LAST_STEP) ? KS_IDLE : KS_RUN;
      default: state_next = KS_IDLE;
    endcase
    // a write to a real key register restarts the expansion
    if (cfg_wr_en && (cfg_index inside {REG_KEY_LOW, REG_KEY_HIGH})) begin
      state_next = KS_LOAD;
    end
  end

  assign l_step = (rotr(l, ALPHA) + k) ^ word_t'(cnt);
  assign k_step = rotl(k, BETA) ^ l_step;
  assign wr_idx = cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    case (state)
      KS_LOAD: begin
        k             <= key_low;
        l             <= key_high;
        cnt           <= '0;
        round_keys[0] <= key_low;
      end
      KS_RUN: begin
        k                  <= k_step;
        l                  <= l_step;
        cnt                <= wr_idx;
        round_keys[wr_idx] <= k_step;
      end
      default: begin
      end
    endcase
  end

  assign keys_ready = (state == KS_IDLE);

endmodule

>>> rtl/core/speck96_round.sv
// ----------------------------------------------------------------------------
// speck96_round
// one registered cipher round, forward or inverse as the item's mode says
// ----------------------------------------------------------------------------
module speck96_round (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  speck96_pkg::stage_t            in_data,
  input  logic [speck96_pkg::WORD_W-1:0] key_enc,
  input  logic [speck96_pkg::WORD_W-1:0] key_dec,
  output logic                           out_valid,
  output speck96_pkg::stage_t            out_data
);
  import speck96_pkg::*;

  word_t  enc_x, enc_y, dec_x, dec_y;
  stage_t result;

  assign enc_x = (rotr(in_data.x, ALPHA) + in_data.y) ^ key_enc;
  assign enc_y = rotl(in_data.y, BETA) ^ enc_x;

  assign dec_y = rotr(in_data.y ^ in_data.x, BETA);
  assign dec_x = rotl((in_data.x ^ key_dec) - dec_y, ALPHA);

  always_comb begin
    result.mode = in_data.mode;
    if (in_data.mode == MODE_DECRYPT) begin
      result.x = dec_x;
      result.y = dec_y;
    end else begin
      result.x = enc_x;
      result.y = enc_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= result;
    end
  end

endmodule

>>> rtl/core/speck96_96_block_cipher.sv
// ----------------------------------------------------------------------------
// speck96_96_block_cipher
// speck 96/96 encrypt / decrypt core, one round per pipeline stage
//
//   channel   dir   beat fields
//   s_axis    in    tdata: in_first_word, in_second_word; tuser: mode
//   m_axis    out   tdata: out_first_word, out_second_word
//   cfg       in    write of key_low_word (0) or key_high_word (1)
//
// takes one block per cycle while keys are ready and the output is not held;
// one register stage per round, the last stage being the output register.
// after reset and after each key register write the schedule unit makes one
// round key per cycle, and s_axis_tready stays low until the schedule is done.
// while a result waits on m_axis_tready the whole pipe holds its place.
// ----------------------------------------------------------------------------
module speck96_96_block_cipher #(
  parameter int ROUND_COUNT = speck96_pkg::ROUND_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [speck96_pkg::DATA_W-1:0]       s_axis_tdata,  // in_first_word, in_second_word
  input  logic                                 s_axis_tuser,  // mode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [speck96_pkg::DATA_W-1:0]       m_axis_tdata,  // out_first_word, out_second_word
  input  logic                                 cfg_wr_en,
  input  logic [speck96_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [speck96_pkg::WORD_W-1:0]       cfg_data
);
  import speck96_pkg::*;

  word_t  round_keys [ROUND_COUNT];
  logic   keys_ready;
  logic   en;
  logic   valid [ROUND_COUNT+1];
  stage_t data  [ROUND_COUNT+1];

  speck96_keys #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_keys (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (round_keys),
    .keys_ready (keys_ready)
  );

  // pipe moves whenever the output register is empty or being drained
  assign en            = !valid[ROUND_COUNT] || m_axis_tready;
  assign s_axis_tready = en && keys_ready;

  assign valid[0]     = s_axis_tvalid && s_axis_tready;
  assign data[0].mode = s_axis_tuser;
  assign data[0].y    = s_axis_tdata[WORD_W-1:0];
  assign data[0].x    = s_axis_tdata[DATA_W-1:WORD_W];

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    speck96_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid[i]),
      .in_data   (data[i]),
      .key_enc   (round_keys[i]),
      .key_dec   (round_keys[ROUND_COUNT-1-i]),
      .out_valid (valid[i+1]),
      .out_data  (data[i+1])
    );
  end

  assign m_axis_tvalid = valid[ROUND_COUNT];
  assign m_axis_tdata  = {data[ROUND_COUNT].x, data[ROUND_COUNT].y};

endmodule

>>> bench/tb_speck96_96_block_cipher.sv
// ----------------------------------------------------------------------------
// tb_speck96_96_block_cipher
// self-checking bench for the speck 96/96 encrypt / decrypt core
//
// an in-bench key schedule and round function predict every output beat.
// blocks stream in under random sender gaps and random output back-pressure.
// a long output stall fills the pipe. keys change between drained bursts,
// including writes to unused register indexes.
// ----------------------------------------------------------------------------
module tb_speck96_96_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import speck96_pkg::*;

  localparam int ROUNDS = ROUND_COUNT_DEF;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam word_t WORD_ONES = {WORD_W{1'b1}};

  typedef struct packed {
    word_t second;
    word_t first;
  } block_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;   // in_first_word, in_second_word
  logic              s_axis_tuser;   // mode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;   // out_first_word, out_second_word
  logic              cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  speck96_96_block_cipher dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // cipher shadow state
  word_t  key_low_shadow;
  word_t  key_high_shadow;
  word_t  round_keys [ROUNDS];
  block_t pending_blocks [$];

  int error_count;
  int sender_idle_pct;
  int receiver_idle_pct;
  int stall_cycles_left;

  function automatic word_t ror48(input word_t v, input int n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t rol48(input word_t v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic void rebuild_round_keys();
    word_t k;
    word_t l;
    k = key_low_shadow;
    l = key_high_shadow;
    round_keys[0] = k;
    for (int i = 0; i < ROUNDS - 1; i++) begin
      l = (ror48(l, ALPHA) + k) ^ word_t'(i);
      k = rol48(k, BETA) ^ l;
      round_keys[i+1] = k;
    end
  endfunction

  function automatic block_t cipher_block(input logic mode, input word_t y_in,
                                          input word_t x_in);
    word_t  y;
    word_t  x;
    block_t b;
    y = y_in;
    x = x_in;
    if (mode == MODE_DECRYPT) begin
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        y = ror48(y ^ x, BETA);
        x = rol48((x ^ round_keys[r]) - y, ALPHA);
      end
    end else begin
      for (int r = 0; r < ROUNDS; r++) begin
        x = (ror48(x, ALPHA) + y) ^ round_keys[r];
        y = rol48(y, BETA) ^ x;
      end
    end
    b.first  = y;
    b.second = x;
    return b;
  endfunction

  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(7))
      0: w = '0;
      1: w = WORD_ONES;
      2: w = word_t'(1) << $urandom_range(WORD_W - 1);
      3: w = ~(word_t'(1) << $urandom_range(WORD_W - 1));
      default: w = word_t'({$urandom, $urandom});
    endcase
    return w;
  endfunction

  // clock and watchdog timeout
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("TB_ERROR");
    $finish;
  end

  // output side: random back-pressure plus an optional long hold-off
  always @(negedge clk) begin
    if (stall_cycles_left > 0) begin
      stall_cycles_left <= stall_cycles_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    block_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_blocks.size() == 0) begin
        $error("output beat with nothing pending: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_blocks.pop_front();
        if (m_axis_tdata[WORD_W-1:0] !== want.first) begin
          $error("out_first_word: expected %h actual %h", want.first,
                 m_axis_tdata[WORD_W-1:0]);
          error_count++;
        end
        if (m_axis_tdata[DATA_W-1:WORD_W] !== want.second) begin
          $error("out_second_word: expected %h actual %h", want.second,
                 m_axis_tdata[DATA_W-1:WORD_W]);
          error_count++;
        end
      end
    end
  end

  // one input beat; returns at the falling edge after acceptance with tvalid still high
  task automatic send_block(input logic mode, input word_t first, input word_t second);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {second, first};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_blocks.push_back(cipher_block(mode, first, second));
    @(negedge clk);
  endtask

  // encrypt then decrypt back (or the other way), both directions checked
  task automatic send_round_trip(input logic first_mode, input word_t first,
                                 input word_t second);
    block_t mid;
    logic   back_mode;
    mid = cipher_block(first_mode, first, second);
    back_mode = (first_mode == MODE_ENCRYPT) ? MODE_DECRYPT : MODE_ENCRYPT;
    send_block(first_mode, first, second);
    send_block(back_mode, mid.first, mid.second);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_blocks.size() != 0) @(negedge clk);
  endtask

  task automatic write_key(input logic [CFG_INDEX_W-1:0] index, input word_t value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (index == REG_KEY_LOW) begin
      key_low_shadow = value;
      rebuild_round_keys();
    end else if (index == REG_KEY_HIGH) begin
      key_high_shadow = value;
      rebuild_round_keys();
    end
    // let the schedule finish before anything else touches the core
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_reset_key();
    send_block(MODE_ENCRYPT, '0, '0);
    send_block(MODE_DECRYPT, '0, '0);
    send_block(MODE_ENCRYPT, WORD_ONES, WORD_ONES);
    send_block(MODE_DECRYPT, WORD_ONES, WORD_ONES);
    send_block(MODE_ENCRYPT, 48'h000000000001, 48'h800000000000);
    send_round_trip(MODE_ENCRYPT, 48'haaaaaaaaaaaa, 48'h555555555555);
    wait_drained();
  endtask

  task automatic test_key_extremes();
    write_key(REG_KEY_LOW, WORD_ONES);
    write_key(REG_KEY_HIGH, WORD_ONES);
    send_block(MODE_ENCRYPT, '0, WORD_ONES);
    send_block(MODE_DECRYPT, WORD_ONES, '0);
    send_round_trip(MODE_DECRYPT, 48'h123456789abc, 48'hfedcba987654);
    wait_drained();
    // published test vector key and plaintext
    write_key(REG_KEY_LOW, 48'h050403020100);
    write_key(REG_KEY_HIGH, 48'h0d0c0b0a0908);
    send_round_trip(MODE_ENCRYPT, 48'h656761737520, 48'h65776f68202c);
    wait_drained();
    // unused indexes must leave the keys alone
    write_key(REG_SPARE_A, WORD_ONES);
    write_key(REG_SPARE_B, 48'h5a5a5a5a5a5a);
    send_block(MODE_ENCRYPT, 48'h656761737520, 48'h65776f68202c);
    send_block(MODE_DECRYPT, 48'h0f0f0f0f0f0f, 48'hf0f0f0f0f0f0);
    wait_drained();
    write_key(REG_KEY_LOW, '0);
    send_block(MODE_ENCRYPT, 48'h800000000000, 48'h000000000001);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int bursts, input int per_burst);
    int sent;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    for (int b = 0; b < bursts; b++) begin
      wait_drained();
      write_key(REG_KEY_LOW, pick_word());
      write_key(REG_KEY_HIGH, pick_word());
      if ($urandom_range(3) == 0)
        write_key($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, pick_word());
      sent = 0;
      while (sent < per_burst) begin
        if ($urandom_range(3) == 0) begin
          send_round_trip(logic'($urandom_range(1)), pick_word(), pick_word());
          sent += 2;
        end else begin
          send_block(logic'($urandom_range(1)), pick_word(), pick_word());
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  task automatic test_output_stall();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    stall_cycles_left = 300;
    for (int i = 0; i < 80; i++)
      send_block(logic'($urandom_range(1)), pick_word(), pick_word());
    // sender holds off until the pipe is empty
    wait_drained();
    for (int i = 0; i < 40; i++)
      send_block(logic'($urandom_range(1)), pick_word(), pick_word());
    wait_drained();
  endtask

  initial begin
    rst               = 1'b1;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    s_axis_tuser      = MODE_ENCRYPT;
    m_axis_tready     = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = REG_KEY_LOW;
    cfg_data          = '0;
    error_count       = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    stall_cycles_left = 0;
    key_low_shadow    = '0;
    key_high_shadow   = '0;
    rebuild_round_keys();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_key();
    test_key_extremes();
    test_random_traffic(6, 76, 4, 100);
    test_random_traffic(76, 6, 4, 100);
    test_random_traffic(0, 0, 4, 100);
    test_output_stall();

    wait_drained();
    repeat (ROUNDS + 8) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/speck96_pkg.sv
rtl/core/speck96_keys.sv
rtl/core/speck96_round.sv
rtl/core/speck96_96_block_cipher.sv
bench/tb_speck96_96_block_cipher.sv
